// ===== hw/rtl/wavhp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wavhp_pkg;

  // Chunk ids as they assemble little-endian from the byte stream
  localparam logic [31:0] ID_WAVE = 32'h45564157;
  localparam logic [31:0] ID_FMT  = 32'h20746D66;
  localparam logic [31:0] ID_DATA = 32'h61746164;
  localparam logic [31:0] ID_LIST = 32'h5453494C;
  localparam logic [31:0] ID_FACT = 32'h74636166;

  localparam logic [31:0] HDR_LEN       = 32'd12;
  localparam logic [31:0] HDR_ID_OFS    = 32'd8;
  localparam logic [31:0] CHUNK_HDR_LEN = 32'd8;
  localparam logic [31:0] CHUNK_ID_LEN  = 32'd4;
  localparam logic [31:0] FMT_SIZE_MIN  = 32'd16;
  localparam logic [31:0] FMT_SIZE_MAX  = 32'd100;

  localparam logic [31:0] FMT_OFS_TAG     = 32'd0;
  localparam logic [31:0] FMT_OFS_CHAN    = 32'd2;
  localparam logic [31:0] FMT_OFS_RATE_LO = 32'd4;
  localparam logic [31:0] FMT_OFS_RATE_HI = 32'd5;
  localparam logic [31:0] FMT_OFS_BITS    = 32'd14;

  localparam logic [7:0] FMT_TAG_PCM = 8'd1;
  localparam logic [7:0] CHAN_MONO   = 8'd1;
  localparam logic [7:0] CHAN_STEREO = 8'd2;
  localparam logic [7:0] BITS_EIGHT  = 8'd8;
  localparam logic [7:0] BITS_SIXTEEN = 8'd16;

  localparam int unsigned CLK_W = 27;
  localparam logic [CLK_W-1:0] CLK_HZ_RESET = 27'd20000000;

  // Dividend is clock_hz / 8; the /64 path reuses its quotient shifted by 3
  localparam int unsigned DVD_W = CLK_W - 3;
  localparam int unsigned STEP_W = 5;
  localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(DVD_W);
  localparam logic [15:0] CMP_LIMIT = 16'd255;

  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = 2;
  localparam int unsigned CMD_CNT_W = 3;

  typedef enum logic [1:0] {
    CMD_FAIL,
    CMD_FMT,
    CMD_OK
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic        has_fmt;
    logic        stereo;
    logic        bits_sixteen;
    logic [15:0] rate;
    logic [31:0] size;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    logic        status;
    logic        stereo;
    logic        bits_sixteen;
    logic [15:0] sample_rate;
    logic [7:0]  compare_value;
    logic        prescale_64;
    logic [31:0] data_size;
  } out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wav_header_parser_unit.sv =====
// A result word reaches the result ports via the command queue and the result register
// after the parse ends; a running timer division or an unread word holds it back.
// Throughput: one byte per cycle while the command queue is not full; each valid fmt
// chunk costs a shift-subtract division in the back end, absorbed by the 4-deep queue.
// Reset (rst_ni, async, active low): parser idle, queues empty, clock_hz = 20000000.
`timescale 1ns / 1ps
`default_nettype none

module wav_header_parser_unit import wavhp_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire in_t              item_i,
  output logic                  empty,
  input  wire logic             pop,
  output out_t                  result_o,
  input  wire logic             cfg_we_i,
  input  wire logic [CLK_W-1:0] cfg_wdata_i
);

  cmd_t cmd_in, cmd_out;
  logic cmd_valid, cmd_pop, cmd_empty;

  wavhp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (item_i),
    .full_i      (full),
    .cmd_o       (cmd_in),
    .cmd_valid_o (cmd_valid)
  );

  wavhp_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  wavhp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .result_o    (result_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

  // front end never issues a command into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid |-> !full)
    else $error("command issued while queue full");

  // a failure word carries nothing but its status
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.status) |-> (result_o.data_size == '0
      && result_o.sample_rate == '0 && result_o.compare_value == '0
      && !result_o.stereo && !result_o.bits_sixteen && !result_o.prescale_64))
    else $error("failure word with nonzero fields");

  // the queue fills only after a command was issued
  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(cmd_valid))
    else $error("queue became full without a command");

  // only fmt commands leave the queue while the result register holds an unread word
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop && cmd_pop) |-> cmd_out.kind == CMD_FMT)
    else $error("result overwritten before pop");

endmodule

`default_nettype wire

// ===== hw/rtl/wavhp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wavhp_front import wavhp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire in_t  item_i,
  input  wire logic full_i,
  output cmd_t      cmd_o,
  output logic      cmd_valid_o
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_CHUNK  = 3'd2;
  localparam logic [2:0] PH_FMT    = 3'd3;
  localparam logic [2:0] PH_SKIP   = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [31:0] cnt_q, cnt_d;
  logic [31:0] id_q, id_d;
  logic [31:0] size_q, size_d;
  logic [7:0]  tag_q, tag_d;
  logic [7:0]  chan_q, chan_d;
  logic [15:0] rate_q, rate_d;
  logic [7:0]  bits_q, bits_d;
  logic        has_fmt_q, has_fmt_d;
  logic [7:0]  b;
  logic        fmt_ok;

  assign b = item_i.data_byte;
  // the last byte of a fmt chunk lies past every captured field
  assign fmt_ok = (tag_q == FMT_TAG_PCM)
               && (chan_q == CHAN_MONO || chan_q == CHAN_STEREO)
               && (bits_q == BITS_EIGHT || bits_q == BITS_SIXTEEN)
               && (rate_q != 16'd0);

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    id_d      = id_q;
    size_d    = size_q;
    tag_d     = tag_q;
    chan_d    = chan_q;
    rate_d    = rate_q;
    bits_d    = bits_q;
    has_fmt_d = has_fmt_q;
    cmd_valid_o = 1'b0;
    cmd_o = '0;
    cmd_o.kind = CMD_FAIL;

    if (push_i && !full_i) begin
      if (item_i.first) begin
        phase_d   = PH_HEADER;
        cnt_d     = '0;
        id_d      = '0;
        size_d    = '0;
        tag_d     = '0;
        chan_d    = '0;
        rate_d    = '0;
        bits_d    = '0;
        has_fmt_d = 1'b0;
      end
      if (phase_d != PH_IDLE) begin
        if (item_i.end_of_file) begin
          cmd_valid_o = 1'b1;
          phase_d = PH_IDLE;
        end else begin
          case (phase_d)
            PH_HEADER: begin
              if (cnt_d >= HDR_ID_OFS) id_d = {b, id_d[31:8]};
              cnt_d = cnt_d + 32'd1;
              if (cnt_d == HDR_LEN) begin
                if (id_d != ID_WAVE) begin
                  cmd_valid_o = 1'b1;
                  phase_d = PH_IDLE;
                end else begin
                  phase_d = PH_CHUNK;
                  cnt_d   = '0;
                  id_d    = '0;
                  size_d  = '0;
                end
              end
            end
            PH_CHUNK: begin
              if (cnt_d < CHUNK_ID_LEN) id_d = {b, id_d[31:8]};
              else size_d = {b, size_d[31:8]};
              cnt_d = cnt_d + 32'd1;
              if (cnt_d == CHUNK_HDR_LEN) begin
                cnt_d = '0;
                if (id_d == ID_FMT) begin
                  if (size_d > FMT_SIZE_MAX || size_d < FMT_SIZE_MIN) begin
                    cmd_valid_o = 1'b1;
                    phase_d = PH_IDLE;
                  end else begin
                    phase_d = PH_FMT;
                  end
                end else if (id_d == ID_DATA) begin
                  cmd_valid_o = 1'b1;
                  cmd_o.kind = CMD_OK;
                  cmd_o.has_fmt = has_fmt_d;
                  cmd_o.stereo = (chan_d == CHAN_STEREO);
                  cmd_o.bits_sixteen = (bits_d == BITS_SIXTEEN);
                  cmd_o.rate = rate_d;
                  cmd_o.size = size_d;
                  phase_d = PH_IDLE;
                end else if (id_d == ID_LIST || id_d == ID_FACT) begin
                  id_d = '0;
                  if (size_d != '0) begin
                    phase_d = PH_SKIP;
                    cnt_d = size_d;
                  end
                  size_d = '0;
                end else begin
                  cmd_valid_o = 1'b1;
                  phase_d = PH_IDLE;
                end
              end
            end
            PH_FMT: begin
              if (cnt_d == FMT_OFS_TAG) tag_d = b;
              else if (cnt_d == FMT_OFS_CHAN) chan_d = b;
              else if (cnt_d == FMT_OFS_RATE_LO) rate_d = {rate_d[15:8], b};
              else if (cnt_d == FMT_OFS_RATE_HI) rate_d = {b, rate_d[7:0]};
              else if (cnt_d == FMT_OFS_BITS) bits_d = b;
              cnt_d = cnt_d + 32'd1;
              if (cnt_d >= size_d) begin
                cmd_valid_o = 1'b1;
                if (fmt_ok) begin
                  // hand the rate to the back end for the timer division
                  cmd_o.kind = CMD_FMT;
                  cmd_o.rate = rate_d;
                  has_fmt_d = 1'b1;
                  phase_d = PH_CHUNK;
                  cnt_d   = '0;
                  id_d    = '0;
                  size_d  = '0;
                end else begin
                  phase_d = PH_IDLE;
                end
              end
            end
            PH_SKIP: begin
              cnt_d = cnt_d - 32'd1;
              if (cnt_d == '0) begin
                phase_d = PH_CHUNK;
                id_d    = '0;
                size_d  = '0;
              end
            end
            default: begin
              phase_d = PH_IDLE;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      cnt_q     <= '0;
      id_q      <= '0;
      size_q    <= '0;
      tag_q     <= '0;
      chan_q    <= '0;
      rate_q    <= '0;
      bits_q    <= '0;
      has_fmt_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      id_q      <= id_d;
      size_q    <= size_d;
      tag_q     <= tag_d;
      chan_q    <= chan_d;
      rate_q    <= rate_d;
      bits_q    <= bits_d;
      has_fmt_q <= has_fmt_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wavhp_cmd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wavhp_cmd_fifo import wavhp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cmd_t      data_o,
  output logic      empty_o
);

  cmd_t                 mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMD_CNT_W-1:0] cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == CMD_CNT_W'(CMD_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + CMD_PTR_W'(1);
      if (do_pop) rd_ptr_q <= rd_ptr_q + CMD_PTR_W'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + CMD_CNT_W'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CMD_CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wavhp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wavhp_back import wavhp_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CLK_W-1:0] cfg_wdata_i,
  input  wire cmd_t             cmd_i,
  input  wire logic             cmd_empty_i,
  output logic                  cmd_pop_o,
  output out_t                  result_o,
  output logic                  empty_o,
  input  wire logic             pop_i
);

  logic [CLK_W-1:0]  clock_q;
  logic              busy_q;
  logic [STEP_W-1:0] steps_q;
  logic [DVD_W-1:0]  dq_q;
  logic [15:0]       rem_q;
  logic [15:0]       dvs_q;
  logic [16:0]       trial;
  logic [16:0]       shifted;
  logic [15:0]       q8, q64;
  logic [7:0]        cmp;
  logic              pre;
  logic              out_valid_q;
  out_t              out_q, out_d;

  // restoring division: one quotient bit per cycle, shifted into dq_q
  assign shifted = {rem_q, dq_q[DVD_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  // timer settings from the finished quotient, 16-bit wrap as specified
  assign q8  = dq_q[15:0] - 16'd1;
  assign q64 = dq_q[18:3] - 16'd1;
  always_comb begin
    if (q8 > CMP_LIMIT) begin
      cmp = q64[7:0];
      pre = 1'b1;
    end else begin
      cmp = q8[7:0];
      pre = 1'b0;
    end
  end

  always_comb begin
    cmd_pop_o = 1'b0;
    case (cmd_i.kind)
      CMD_FMT: cmd_pop_o = !busy_q && !cmd_empty_i;
      CMD_OK,
      CMD_FAIL: cmd_pop_o = !busy_q && !cmd_empty_i && (!out_valid_q || pop_i);
      default: cmd_pop_o = !busy_q && !cmd_empty_i && (!out_valid_q || pop_i);
    endcase
  end

  always_comb begin
    out_d = '0;
    if (cmd_i.kind == CMD_OK) begin
      out_d.stereo       = cmd_i.stereo;
      out_d.bits_sixteen = cmd_i.bits_sixteen;
      out_d.sample_rate  = cmd_i.rate;
      out_d.data_size    = cmd_i.size;
      if (cmd_i.has_fmt) begin
        out_d.compare_value = cmp;
        out_d.prescale_64   = pre;
      end
    end else begin
      out_d.status = 1'b1;
    end
  end

  assign result_o = out_q;
  assign empty_o  = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q     <= CLK_HZ_RESET;
      busy_q      <= 1'b0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) clock_q <= cfg_wdata_i;
      if (cmd_pop_o && cmd_i.kind == CMD_FMT) begin
        busy_q  <= 1'b1;
        steps_q <= DIV_STEPS;
      end else if (busy_q) begin
        steps_q <= steps_q - STEP_W'(1);
        if (steps_q == STEP_W'(1)) busy_q <= 1'b0;
      end
      if (cmd_pop_o && cmd_i.kind != CMD_FMT) out_valid_q <= 1'b1;
      else if (pop_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && cmd_i.kind == CMD_FMT) begin
      dq_q  <= clock_q[CLK_W-1:3];
      rem_q <= '0;
      dvs_q <= cmd_i.rate;
    end else if (busy_q) begin
      if (!trial[16]) begin
        rem_q <= trial[15:0];
        dq_q  <= {dq_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[15:0];
        dq_q  <= {dq_q[DVD_W-2:0], 1'b0};
      end
    end
    if (cmd_pop_o && cmd_i.kind != CMD_FMT) out_q <= out_d;
  end

endmodule

`default_nettype wire

// ===== tb/wav_header_checker.sv =====
`timescale 1ns / 1ps

module wav_header_checker import wavhp_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  input  wire logic             full,
  input  wire in_t              item_i,
  input  wire logic             empty,
  input  wire logic             pop,
  input  wire out_t             result_i,
  input  wire logic             cfg_we_i,
  input  wire logic [CLK_W-1:0] cfg_wdata_i,
  output int                    mismatches_o,
  output int                    pending_o,
  output int                    reports_o
);

  typedef enum logic [2:0] {
    PS_IDLE,
    PS_HEADER,
    PS_CHUNK,
    PS_FMT,
    PS_SKIP
  } parse_state_e;

  parse_state_e     pstate;
  logic [31:0]      pos;
  logic [31:0]      cid;
  logic [31:0]      csize;
  logic [7:0]       tag;
  logic [7:0]       chans;
  logic [7:0]       bits_per;
  logic [15:0]      rate;
  logic [7:0]       cmp;
  logic             pre64;
  logic [CLK_W-1:0] clk_hz;

  out_t header_reports_q[$];

  task automatic clear_parse();
    pos = '0;
    cid = '0;
    csize = '0;
    tag = '0;
    chans = '0;
    bits_per = '0;
    rate = '0;
    cmp = '0;
    pre64 = 1'b0;
  endtask

  // Advance the parse by one word; got is set when the word ends the parse.
  task automatic parse_byte(input in_t w, output bit got, output out_t r);
    logic [31:0] b;
    logic [31:0] q;
    bit reject;
    bit accept;
    b = {24'b0, w.data_byte};
    got = 1'b0;
    r = '0;
    reject = 1'b0;
    accept = 1'b0;
    if (w.first) begin
      clear_parse();
      pstate = PS_HEADER;
    end else if (pstate == PS_IDLE) begin
      return;
    end
    if (w.end_of_file) begin
      reject = 1'b1;
    end else begin
      case (pstate)
        PS_HEADER: begin
          if (pos >= HDR_ID_OFS) cid = cid | (b << (8 * pos[1:0]));
          pos = pos + 1;
          if (pos == HDR_LEN) begin
            if (cid != ID_WAVE) begin
              reject = 1'b1;
            end else begin
              pstate = PS_CHUNK;
              pos = '0;
              cid = '0;
              csize = '0;
            end
          end
        end
        PS_CHUNK: begin
          if (pos < CHUNK_ID_LEN) cid = cid | (b << (8 * pos[1:0]));
          else csize = csize | (b << (8 * pos[1:0]));
          pos = pos + 1;
          if (pos == CHUNK_HDR_LEN) begin
            pos = '0;
            if (cid == ID_FMT) begin
              if (csize > FMT_SIZE_MAX || csize < FMT_SIZE_MIN) reject = 1'b1;
              else pstate = PS_FMT;
            end else if (cid == ID_DATA) begin
              accept = 1'b1;
            end else if (cid == ID_LIST || cid == ID_FACT) begin
              cid = '0;
              if (csize != 0) begin
                pstate = PS_SKIP;
                pos = csize;
              end
              csize = '0;
            end else begin
              reject = 1'b1;
            end
          end
        end
        PS_FMT: begin
          if (pos == FMT_OFS_TAG) tag = w.data_byte;
          else if (pos == FMT_OFS_CHAN) chans = w.data_byte;
          else if (pos == FMT_OFS_RATE_LO) rate[7:0] = w.data_byte;
          else if (pos == FMT_OFS_RATE_HI) rate[15:8] = w.data_byte;
          else if (pos == FMT_OFS_BITS) bits_per = w.data_byte;
          pos = pos + 1;
          if (pos >= csize) begin
            if (tag != FMT_TAG_PCM || (chans != CHAN_MONO && chans != CHAN_STEREO) ||
                (bits_per != BITS_EIGHT && bits_per != BITS_SIXTEEN) || rate == 0) begin
              reject = 1'b1;
            end else begin
              // Divide by 8 first; fall back to 64 when the 16-bit value overflows a byte
              q = {5'b0, clk_hz} / 32'd8 / {16'b0, rate} - 32'd1;
              pre64 = 1'b0;
              if (q[15:0] > CMP_LIMIT) begin
                q = {5'b0, clk_hz} / 32'd64 / {16'b0, rate} - 32'd1;
                pre64 = 1'b1;
              end
              cmp = q[7:0];
              pstate = PS_CHUNK;
              pos = '0;
              cid = '0;
              csize = '0;
            end
          end
        end
        PS_SKIP: begin
          pos = pos - 1;
          if (pos == 0) begin
            pstate = PS_CHUNK;
            cid = '0;
            csize = '0;
          end
        end
        default: pstate = PS_IDLE;
      endcase
    end
    if (reject) begin
      got = 1'b1;
      r.status = 1'b1;
      pstate = PS_IDLE;
    end else if (accept) begin
      got = 1'b1;
      r.status = 1'b0;
      r.stereo = (chans == CHAN_STEREO);
      r.bits_sixteen = (bits_per == BITS_SIXTEEN);
      r.sample_rate = rate;
      r.compare_value = cmp;
      r.prescale_64 = pre64;
      r.data_size = csize;
      pstate = PS_IDLE;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bit   got;
    out_t want;
    out_t fresh;
    if (!rst_ni) begin
      pstate = PS_IDLE;
      clear_parse();
      clk_hz = CLK_HZ_RESET;
      header_reports_q.delete();
      mismatches_o = 0;
      reports_o = 0;
      pending_o <= 0;
    end else begin
      if (pop && !empty) begin
        if (header_reports_q.size() == 0) begin
          if (mismatches_o < 10)
            $display("%0t: result word with no report outstanding: %h", $time, result_i);
          mismatches_o++;
        end else begin
          want = header_reports_q.pop_front();
          if (result_i.status !== want.status || result_i.stereo !== want.stereo ||
              result_i.bits_sixteen !== want.bits_sixteen ||
              result_i.sample_rate !== want.sample_rate ||
              result_i.compare_value !== want.compare_value ||
              result_i.prescale_64 !== want.prescale_64 ||
              result_i.data_size !== want.data_size) begin
            if (mismatches_o < 10) begin
              $display("%0t: report %0d expected st=%0d ch2=%0d b16=%0d rate=%0d cmp=%0d p64=%0d size=%h",
                       $time, reports_o, want.status, want.stereo, want.bits_sixteen,
                       want.sample_rate, want.compare_value, want.prescale_64, want.data_size);
              $display("%0t: report %0d actual   st=%0d ch2=%0d b16=%0d rate=%0d cmp=%0d p64=%0d size=%h",
                       $time, reports_o, result_i.status, result_i.stereo, result_i.bits_sixteen,
                       result_i.sample_rate, result_i.compare_value, result_i.prescale_64,
                       result_i.data_size);
            end
            mismatches_o++;
          end
          reports_o++;
        end
      end
      if (push && !full) begin
        parse_byte(item_i, got, fresh);
        if (got) header_reports_q.push_back(fresh);
      end
      if (cfg_we_i) clk_hz = cfg_wdata_i;
      pending_o <= header_reports_q.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import wavhp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned BYTES_WANTED = 1950;
  localparam int unsigned NUM_SETTINGS = 6;
  localparam int unsigned MIN_FILES    = 2;
  // Covers the parse latency plus a full command queue of timer divisions
  localparam int unsigned SETTLE       = 150;
  localparam logic [31:0] ID_RIFF      = 32'h46464952;
  localparam logic [31:0] ID_JUNK      = 32'h4B4E554A;

  logic             clk_i;
  logic             rst_ni;
  logic             push;
  logic             full;
  in_t              item;
  logic             empty;
  logic             pop;
  out_t             result;
  logic             cfg_we;
  logic [CLK_W-1:0] cfg_wdata;

  int          mismatches;
  int          pending;
  int          reports;
  bit          calm;
  int unsigned cycles;
  int unsigned bytes_sent;
  int unsigned files_sent;
  logic [7:0]  file_q[$];

  wav_header_parser_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .item_i     (item),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  wav_header_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item),
    .empty       (empty),
    .pop         (pop),
    .result_i    (result),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .mismatches_o(mismatches),
    .pending_o   (pending),
    .reports_o   (reports)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk_i) begin
    pop <= calm || ($urandom_range(0, 99) >= 7);
  end

  // Offer one word and hold it until the block takes it
  task automatic put(input logic [7:0] b, input logic f, input logic e);
    in_t w;
    w.data_byte = b;
    w.first = f;
    w.end_of_file = e;
    while (!calm && $urandom_range(0, 99) < 7) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    item <= w;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic add_word(input logic [31:0] v);
    int unsigned k;
    for (k = 0; k < 4; k++) file_q.push_back(v[8*k +: 8]);
  endtask

  task automatic start_file();
    file_q.delete();
    add_word(ID_RIFF);
    add_word($urandom());
    add_word(ID_WAVE);
  endtask

  task automatic add_fmt(input logic [31:0] size, input logic [7:0] tag,
                         input logic [7:0] chans, input logic [15:0] rate,
                         input logic [7:0] bits_per);
    logic [31:0] n;
    logic [31:0] k;
    add_word(ID_FMT);
    add_word(size);
    // An oversized chunk is rejected at its header, so only four body bytes are sent
    n = (size > FMT_SIZE_MAX) ? 32'd4 : size;
    for (k = 0; k < n; k++) begin
      if (k == FMT_OFS_TAG) file_q.push_back(tag);
      else if (k == FMT_OFS_CHAN) file_q.push_back(chans);
      else if (k == FMT_OFS_RATE_LO) file_q.push_back(rate[7:0]);
      else if (k == FMT_OFS_RATE_HI) file_q.push_back(rate[15:8]);
      else if (k == FMT_OFS_BITS) file_q.push_back(bits_per);
      else file_q.push_back(8'($urandom()));
    end
  endtask

  task automatic add_skip(input logic [31:0] id, input logic [31:0] size);
    logic [31:0] k;
    add_word(id);
    add_word(size);
    for (k = 0; k < size; k++) file_q.push_back(8'($urandom()));
  endtask

  task automatic add_random_fmt();
    int unsigned   pick;
    logic [31:0]   size;
    logic [15:0]   rate;
    logic [7:0]    tag;
    logic [7:0]    chans;
    logic [7:0]    bits_per;
    pick = $urandom_range(0, 99);
    if (pick < 75) size = FMT_SIZE_MIN;
    else if (pick < 88) size = $urandom_range(17, 99);
    else if (pick < 93) size = FMT_SIZE_MAX;
    else if (pick < 96) size = $urandom_range(0, 15);
    else if (pick < 98) size = $urandom_range(101, 255);
    else size = $urandom();
    tag = ($urandom_range(0, 99) < 95) ? FMT_TAG_PCM : 8'($urandom());
    if ($urandom_range(0, 99) < 95) chans = $urandom_range(0, 1) ? CHAN_STEREO : CHAN_MONO;
    else chans = 8'($urandom());
    if ($urandom_range(0, 99) < 95) bits_per = $urandom_range(0, 1) ? BITS_SIXTEEN : BITS_EIGHT;
    else bits_per = 8'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      case ($urandom_range(0, 6))
        0: rate = 16'd8000;
        1: rate = 16'd11025;
        2: rate = 16'd16000;
        3: rate = 16'd22050;
        4: rate = 16'd32000;
        5: rate = 16'd44100;
        default: rate = 16'd48000;
      endcase
    end else if (pick < 85) begin
      rate = 16'($urandom_range(1, 65535));
    end else if (pick < 95) begin
      rate = 16'($urandom_range(1, 20));
    end else begin
      rate = '0;
    end
    add_fmt(size, tag, chans, rate, bits_per);
  endtask

  task automatic send_file(input int unsigned cut);
    int unsigned i;
    for (i = 0; i < cut; i++) put(file_q[i], i == 0, 1'b0);
    bytes_sent += cut;
    files_sent++;
  endtask

  task automatic fmt_file(input logic [31:0] size, input logic [7:0] tag,
                          input logic [7:0] chans, input logic [15:0] rate,
                          input logic [7:0] bits_per);
    start_file();
    add_fmt(size, tag, chans, rate, bits_per);
    add_word(ID_DATA);
    add_word($urandom());
    send_file(file_q.size());
  endtask

  // Register writes only once the block has drained and any division is done
  task automatic set_clock(input logic [CLK_W-1:0] hz);
    push <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= hz;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned  setting;
    int unsigned  start_files;
    int unsigned  pick;
    int unsigned  nchunks;
    int unsigned  k;
    int unsigned  cut;
    logic [31:0]  len;
    rst_ni = 1'b0;
    push = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    calm = 1'b0;
    bytes_sent = 0;
    files_sent = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Words before any file start, and an end of file while idle: dropped
    put(8'hA5, 1'b0, 1'b0);
    put(8'h5A, 1'b0, 1'b1);
    // Empty file
    put(8'hFF, 1'b1, 1'b1);
    start_file();
    add_fmt(FMT_SIZE_MIN, FMT_TAG_PCM, CHAN_STEREO, 16'd44100, BITS_SIXTEEN);
    add_word(ID_DATA);
    add_word(32'hFFFF_FFFF);
    send_file(file_q.size());
    // Trailing bytes after the result are dropped
    put(8'h00, 1'b0, 1'b0);
    put(8'h3C, 1'b0, 1'b1);
    start_file();
    add_fmt(FMT_SIZE_MAX, FMT_TAG_PCM, CHAN_MONO, 16'hFFFF, BITS_EIGHT);
    add_skip(ID_LIST, 32'd3);
    add_word(ID_DATA);
    add_word(32'h0000_0000);
    send_file(file_q.size());
    fmt_file(FMT_SIZE_MIN, FMT_TAG_PCM, CHAN_MONO, 16'd1, BITS_EIGHT);
    // Data with no fmt before it
    start_file();
    add_word(ID_DATA);
    add_word(32'h1234_5678);
    send_file(file_q.size());
    // Two fmt chunks around an empty fact chunk: the second one wins
    start_file();
    add_fmt(FMT_SIZE_MIN, FMT_TAG_PCM, CHAN_MONO, 16'd8000, BITS_EIGHT);
    add_skip(ID_FACT, 32'd0);
    add_fmt(32'd41, FMT_TAG_PCM, CHAN_STEREO, 16'd48000, BITS_SIXTEEN);
    add_word(ID_DATA);
    add_word(32'h8000_0001);
    send_file(file_q.size());
    // Broken WAVE tag
    start_file();
    file_q[HDR_LEN - 1] = 8'h00;
    send_file(file_q.size());
    fmt_file(32'd15, FMT_TAG_PCM, CHAN_MONO, 16'd8000, BITS_EIGHT);
    fmt_file(32'd101, FMT_TAG_PCM, CHAN_MONO, 16'd8000, BITS_EIGHT);
    fmt_file(FMT_SIZE_MIN, FMT_TAG_PCM, CHAN_MONO, 16'd0, BITS_EIGHT);
    fmt_file(FMT_SIZE_MIN, 8'd3, CHAN_MONO, 16'd8000, BITS_EIGHT);
    fmt_file(FMT_SIZE_MIN, FMT_TAG_PCM, 8'd0, 16'd8000, BITS_EIGHT);
    fmt_file(FMT_SIZE_MIN, FMT_TAG_PCM, 8'd3, 16'd8000, BITS_SIXTEEN);
    fmt_file(FMT_SIZE_MIN, FMT_TAG_PCM, CHAN_STEREO, 16'd8000, 8'd24);
    // Unknown chunk
    start_file();
    add_skip(ID_JUNK, 32'd4);
    send_file(file_q.size());
    // Early end of file inside fmt, then a restart in the middle of a file
    start_file();
    add_fmt(FMT_SIZE_MIN, FMT_TAG_PCM, CHAN_STEREO, 16'd22050, BITS_SIXTEEN);
    send_file(20);
    put(8'hC3, 1'b0, 1'b1);
    send_file(30);
    fmt_file(FMT_SIZE_MIN, FMT_TAG_PCM, CHAN_STEREO, 16'd11025, BITS_EIGHT);

    for (setting = 0; setting < NUM_SETTINGS; setting++) begin
      case (setting)
        1: set_clock(27'd100000000);
        2: set_clock(27'd1);
        3: set_clock(CLK_W'($urandom_range(1, 100000000)));
        4: set_clock(27'd8000000);
        5: set_clock(CLK_HZ_RESET);
        default: ;
      endcase
      calm = (setting == 2);
      start_files = files_sent;
      while (bytes_sent < BYTES_WANTED * (setting + 1) / NUM_SETTINGS ||
             files_sent - start_files < MIN_FILES) begin
        start_file();
        if ($urandom_range(0, 99) < 3)
          file_q[HDR_ID_OFS + $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
        nchunks = $urandom_range(1, 3);
        for (k = 0; k < nchunks; k++) begin
          pick = $urandom_range(0, 99);
          if ($urandom_range(0, 99) < 70) len = $urandom_range(0, 12);
          else if ($urandom_range(0, 99) < 85) len = $urandom_range(13, 64);
          else len = $urandom_range(65, 300);
          if (pick < 60) add_random_fmt();
          else if (pick < 78) add_skip(ID_LIST, len);
          else if (pick < 96) add_skip(ID_FACT, len);
          else add_skip($urandom(), len);
        end
        add_word(ID_DATA);
        add_word($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          put(8'($urandom()), 1'b1, 1'b1);
          files_sent++;
        end else if (pick < 10) begin
          cut = $urandom_range(1, file_q.size() - 1);
          send_file(cut);
          if ($urandom_range(0, 99) < 60) put(8'($urandom()), 1'b0, 1'b1);
        end else begin
          send_file(file_q.size());
          if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 3)) put(8'($urandom()), 1'b0, 1'b0);
            if ($urandom_range(0, 1)) put(8'($urandom()), 1'b0, 1'b1);
          end
        end
      end
    end

    push <= 1'b0;
    calm = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    $display("Sent %0d file bytes in %0d files under %0d clock settings.",
             bytes_sent, files_sent, NUM_SETTINGS);
    $display("Checked %0d header reports; %0d left outstanding.", reports, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
